>>> sv/svpwm_pkg.sv
package svpwm_pkg;

  // Sample width of the alpha/beta references and the phase duties
  localparam int DATA_WIDTH = 16;

  // Q15 coefficients: 1/2 is 2^14, so it is applied as a shift
  localparam int FRAC_BITS  = 15;
  localparam int HALF_SHIFT = 14;
  localparam logic signed [16:0] SQRT3_HALF_Q15 = 17'sd28378;

  // Exact sum beta/2 + alpha*sqrt(3)/2 before rounding, and the rounded y
  localparam int PROD_W = DATA_WIDTH + 17;
  localparam int Y_W    = PROD_W - FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (FRAC_BITS - 1);

  // Width of the unsaturated phase terms (2y - x and similar)
  localparam int T_W = DATA_WIDTH + 4;

  localparam logic signed [DATA_WIDTH-1:0] DUTY_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DUTY_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Sector codes
  localparam logic [2:0] SECT_BASE   = 3'd3;
  localparam logic [2:0] SECT_MIRROR = 3'd7;
  localparam logic [2:0] SECTOR_1    = 3'd1;
  localparam logic [2:0] SECTOR_2    = 3'd2;
  localparam logic [2:0] SECTOR_4    = 3'd4;
  localparam logic [2:0] SECTOR_5    = 3'd5;

  // Projection stage result: x = beta, y = rounded beta/2 + alpha*sqrt(3)/2
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [Y_W-1:0]        y;
  } proj_t;

  // Selection stage result: unsaturated phase terms and sector
  typedef struct packed {
    logic signed [T_W-1:0] ta;
    logic signed [T_W-1:0] tb;
    logic signed [T_W-1:0] tc;
    logic [2:0]            sec;
  } sel_t;

  // Clamp a phase term to the signed output range
  function automatic logic signed [DATA_WIDTH-1:0] sat_duty(input logic signed [T_W-1:0] v);
    logic signed [T_W-1:0]        hi;
    logic signed [T_W-1:0]        lo;
    logic signed [DATA_WIDTH-1:0] r;
    hi = T_W'(DUTY_MAX);
    lo = T_W'(DUTY_MIN);
    if (v > hi) begin
      r = DUTY_MAX;
    end else if (v < lo) begin
      r = DUTY_MIN;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/svpwm_sector_and_duty.sv
// Throughput: one beat per cycle; four pipeline registers (multiply, round,
// sector select, saturate) each hold one beat; a stage holds only while the
// stage after it is full and stalled, so out_ready low stalls the input once all four are full.
// Reset (rst_n low, synchronous) empties every stage; no other state is kept.
module svpwm_sector_and_duty import svpwm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_v_alpha,
  input  logic signed [DATA_WIDTH-1:0] in_v_beta,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_phase_a_duty,
  output logic signed [DATA_WIDTH-1:0] out_phase_b_duty,
  output logic signed [DATA_WIDTH-1:0] out_phase_c_duty,
  output logic [2:0]                   out_sector
);

  logic  proj_valid;
  logic  proj_ready;
  proj_t proj_data;
  logic  sel_valid;
  logic  sel_ready;
  sel_t  sel_data;

  // Project alpha/beta onto the x/y axes
  svpwm_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (in_valid),
    .i_ready   (in_ready),
    .i_v_alpha (in_v_alpha),
    .i_v_beta  (in_v_beta),
    .o_valid   (proj_valid),
    .o_ready   (proj_ready),
    .o_data    (proj_data)
  );

  // Sector and phase term selection
  svpwm_sel u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (proj_valid),
    .i_ready (proj_ready),
    .i_data  (proj_data),
    .o_valid (sel_valid),
    .o_ready (sel_ready),
    .o_data  (sel_data)
  );

  // Saturate and drive the result ports
  svpwm_sat u_sat (
    .clk            (clk),
    .rst_n          (rst_n),
    .i_valid        (sel_valid),
    .i_ready        (sel_ready),
    .i_data         (sel_data),
    .o_valid        (out_valid),
    .o_ready        (out_ready),
    .o_phase_a_duty (out_phase_a_duty),
    .o_phase_b_duty (out_phase_b_duty),
    .o_phase_c_duty (out_phase_c_duty),
    .o_sector       (out_sector)
  );

endmodule

>>> sv/svpwm_proj.sv
module svpwm_proj import svpwm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         i_valid,
  output logic                         i_ready,
  input  logic signed [DATA_WIDTH-1:0] i_v_alpha,
  input  logic signed [DATA_WIDTH-1:0] i_v_beta,
  output logic                         o_valid,
  input  logic                         o_ready,
  output proj_t                        o_data
);

  logic                         s1_valid_r;
  logic signed [PROD_W-1:0]     s1_prod_r;
  logic signed [DATA_WIDTH-1:0] s1_beta_r;
  logic signed [PROD_W-1:0]     s1_prod_nxt;
  logic                         s1_ready;

  logic                         s2_valid_r;
  proj_t                        s2_data_r;
  proj_t                        s2_data_nxt;
  logic signed [PROD_W-1:0]     sum;
  logic                         s2_ready;

  // Advance a stage when it is empty or its beat moves on
  assign s2_ready = !s2_valid_r || o_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign i_ready  = s1_ready;

  // Stage 1: alpha times sqrt(3)/2
  assign s1_prod_nxt = PROD_W'(i_v_alpha) * PROD_W'(SQRT3_HALF_Q15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && i_valid) begin
      s1_prod_r <= s1_prod_nxt;
      s1_beta_r <= i_v_beta;
    end
  end

  // Stage 2: add beta/2, round half up, drop the Q15 fraction
  always_comb begin
    sum           = s1_prod_r + (PROD_W'(s1_beta_r) <<< HALF_SHIFT) + ROUND_BIAS;
    s2_data_nxt.x = s1_beta_r;
    s2_data_nxt.y = sum[PROD_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign o_valid = s2_valid_r;
  assign o_data  = s2_data_r;

endmodule

>>> sv/svpwm_sel.sv
module svpwm_sel import svpwm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  i_valid,
  output logic  i_ready,
  input  proj_t i_data,
  output logic  o_valid,
  input  logic  o_ready,
  output sel_t  o_data
);

  logic                  valid_r;
  sel_t                  data_r;
  sel_t                  data_nxt;
  logic signed [T_W-1:0] xe;
  logic signed [T_W-1:0] ye;
  logic signed [T_W-1:0] ze;
  logic                  y_pos;
  logic                  z_pos;
  logic                  x_neg;
  logic [2:0]            sec;

  assign i_ready = !valid_r || o_ready;

  // Find the sector and pick the phase terms for its pair
  always_comb begin
    xe    = T_W'(i_data.x);
    ye    = T_W'(i_data.y);
    ze    = ye - xe;
    y_pos = !ye[T_W-1] && (ye != '0);
    z_pos = !ze[T_W-1] && (ze != '0);
    x_neg = i_data.x[DATA_WIDTH-1];
    sec   = SECT_BASE - {2'b00, y_pos} - {2'b00, z_pos};
    if (x_neg) begin
      sec = SECT_MIRROR - sec;
    end
    data_nxt.sec = sec;
    if (sec inside {SECTOR_1, SECTOR_4}) begin
      data_nxt.ta = ye;
      data_nxt.tb = xe - ze;
      data_nxt.tc = -ye;
    end else if (sec inside {SECTOR_2, SECTOR_5}) begin
      data_nxt.ta = ze + ye;
      data_nxt.tb = xe;
      data_nxt.tc = -xe;
    end else begin
      data_nxt.ta = ze;
      data_nxt.tb = -ze;
      data_nxt.tc = -(xe + ye);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

>>> sv/svpwm_sat.sv
module svpwm_sat import svpwm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         i_valid,
  output logic                         i_ready,
  input  sel_t                         i_data,
  output logic                         o_valid,
  input  logic                         o_ready,
  output logic signed [DATA_WIDTH-1:0] o_phase_a_duty,
  output logic signed [DATA_WIDTH-1:0] o_phase_b_duty,
  output logic signed [DATA_WIDTH-1:0] o_phase_c_duty,
  output logic [2:0]                   o_sector
);

  logic                         valid_r;
  logic signed [DATA_WIDTH-1:0] ta_r;
  logic signed [DATA_WIDTH-1:0] tb_r;
  logic signed [DATA_WIDTH-1:0] tc_r;
  logic [2:0]                   sec_r;

  assign i_ready = !valid_r || o_ready;

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  // Clamp each phase term into the output range
  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      ta_r  <= sat_duty(i_data.ta);
      tb_r  <= sat_duty(i_data.tb);
      tc_r  <= sat_duty(i_data.tc);
      sec_r <= i_data.sec;
    end
  end

  assign o_valid        = valid_r;
  assign o_phase_a_duty = ta_r;
  assign o_phase_b_duty = tb_r;
  assign o_phase_c_duty = tc_r;
  assign o_sector       = sec_r;

endmodule
